// ===== rtl/kms_pkg.sv =====
// kms_pkg: shared constants for the key matrix scanner.
// Used by kms_front, kms_queue, kms_back and key_matrix_scanner.
`timescale 1ns / 1ps

package kms_pkg;

    localparam int ROW_COUNT_DEF    = 4;
    localparam int COLUMN_COUNT_DEF = 4;

    // fixed port widths
    localparam int ROW_LEVELS_W = 4;
    localparam int DRIVE_W      = 4;
    localparam int EV_COL_W     = 2;
    localparam int EV_ROW_W     = 2;
    localparam int MASK_W       = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;

    // room for any row or column number before trimming to port width
    localparam int WIDE_W = 8;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_EN   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_EN = 2'd1;

endpackage

// ===== rtl/kms_front.sv =====
// kms_front: enable registers, column counter and key bitmap.
// Turns each scan tick into a queue entry {column, release flags, event flags}.
// Depends on kms_pkg.
`timescale 1ns / 1ps

module kms_front
    import kms_pkg::*;
#(
    parameter int ROW_COUNT    = ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = COLUMN_COUNT_DEF,
    localparam int COL_W       = $clog2(COLUMN_COUNT),
    localparam int ENTRY_W     = COL_W + 2 * ROW_COUNT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [ROW_LEVELS_W-1:0] s_row_levels,
    output logic                    q_push,
    output logic [ENTRY_W-1:0]      q_data,
    input  logic                    q_full
);

    logic [MASK_W-1:0] press_en_reg;
    logic [MASK_W-1:0] release_en_reg;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [COLUMN_COUNT-1:0][ROW_COUNT-1:0] bitmap_reg;
    logic [COLUMN_COUNT-1:0][ROW_COUNT-1:0] bitmap_next;
    logic [COLUMN_COUNT-1:0][ROW_COUNT-1:0] press_en_map;
    logic [COLUMN_COUNT-1:0][ROW_COUNT-1:0] release_en_map;
    logic [ROW_COUNT-1:0] levels;
    logic [ROW_COUNT-1:0] pressed;
    logic [ROW_COUNT-1:0] was;
    logic [ROW_COUNT-1:0] fall;
    logic [ROW_COUNT-1:0] ev;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign q_push    = s_valid && s_ready;

    // keys numbered 16 and up have no enable bit
    for (genvar c = 0; c < COLUMN_COUNT; c++) begin : g_col
        for (genvar r = 0; r < ROW_COUNT; r++) begin : g_row
            if (c * ROW_COUNT + r < MASK_W) begin : g_en
                assign press_en_map[c][r]   = press_en_reg[c * ROW_COUNT + r];
                assign release_en_map[c][r] = release_en_reg[c * ROW_COUNT + r];
            end else begin : g_no_en
                assign press_en_map[c][r]   = 1'b0;
                assign release_en_map[c][r] = 1'b0;
            end
        end
    end

    // rows beyond the port read as released
    for (genvar r = 0; r < ROW_COUNT; r++) begin : g_lvl
        if (r < ROW_LEVELS_W) begin : g_port
            assign levels[r] = s_row_levels[r];
        end else begin : g_idle
            assign levels[r] = 1'b1;
        end
    end

    always_comb begin
        col_next = (col_reg == COL_W'(COLUMN_COUNT - 1)) ? '0 : col_reg + COL_W'(1);
        pressed  = ~levels;
        was      = bitmap_reg[col_next];
        fall     = ~pressed & was;
        ev       = (pressed & ~was & press_en_map[col_next])
                 | (fall & release_en_map[col_next]);
        bitmap_next           = bitmap_reg;
        bitmap_next[col_next] = pressed;
        q_data   = {col_next, fall, ev};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_en_reg   <= '0;
            release_en_reg <= '0;
            col_reg        <= '0;
            bitmap_reg     <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PRESS_EN:   press_en_reg   <= cfg_data;
                    REG_RELEASE_EN: release_en_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (q_push) begin
                col_reg    <= col_next;
                bitmap_reg <= bitmap_next;
            end
        end
    end

endmodule

// ===== rtl/kms_queue.sv =====
// kms_queue: small FIFO of classified scan ticks between front and back.
// Depends on kms_pkg.
`timescale 1ns / 1ps

module kms_queue
    import kms_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/kms_back.sv =====
// kms_back: walks the event flags of one queue entry, lowest row first,
// one result item per cycle into the output register while m_ready does not stall it. Depends on kms_pkg.
`timescale 1ns / 1ps

module kms_back
    import kms_pkg::*;
#(
    parameter int ROW_COUNT    = ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = COLUMN_COUNT_DEF,
    localparam int COL_W       = $clog2(COLUMN_COUNT),
    localparam int RIDX_W      = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1,
    localparam int ENTRY_W     = COL_W + 2 * ROW_COUNT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  logic [ENTRY_W-1:0]   q_data,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DRIVE_W-1:0]   m_column_drive,
    output logic                 m_event_valid,
    output logic [EV_COL_W-1:0]  m_event_column,
    output logic [EV_ROW_W-1:0]  m_event_row,
    output logic                 m_event_release,
    output logic                 m_last
);

    logic                 busy_reg;
    logic [ROW_COUNT-1:0] pend_reg;
    logic [ROW_COUNT-1:0] rel_reg;
    logic [COL_W-1:0]     col_reg;

    logic                 m_valid_reg;
    logic [DRIVE_W-1:0]   drive_reg;
    logic                 ev_valid_reg;
    logic [EV_COL_W-1:0]  ev_col_reg;
    logic [EV_ROW_W-1:0]  ev_row_reg;
    logic                 ev_rel_reg;
    logic                 last_reg;

    logic                 advance;
    logic                 have;
    logic [ROW_COUNT-1:0] src_mask;
    logic [ROW_COUNT-1:0] src_rel;
    logic [COL_W-1:0]     src_col;
    logic [ROW_COUNT-1:0] remain;
    logic [RIDX_W-1:0]    idx;
    logic                 any_ev;
    logic [WIDE_W-1:0]    drive_wide;
    logic [WIDE_W-1:0]    col_wide;
    logic [WIDE_W-1:0]    row_wide;

    assign advance = !m_valid_reg || m_ready;
    assign have    = busy_reg || !q_empty;
    assign q_pop   = advance && !busy_reg && !q_empty;

    always_comb begin
        src_mask = busy_reg ? pend_reg : q_data[ROW_COUNT-1:0];
        src_rel  = busy_reg ? rel_reg  : q_data[2*ROW_COUNT-1:ROW_COUNT];
        src_col  = busy_reg ? col_reg  : q_data[ENTRY_W-1 -: COL_W];
        remain   = src_mask & (src_mask - ROW_COUNT'(1));
        any_ev   = |src_mask;
        idx      = '0;
        for (int i = ROW_COUNT - 1; i >= 0; i--) begin
            if (src_mask[i]) begin
                idx = RIDX_W'(i);
            end
        end
        drive_wide = WIDE_W'(1) << src_col;
        col_wide   = WIDE_W'(src_col);
        row_wide   = WIDE_W'(idx);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            busy_reg    <= have && (remain != '0);
            m_valid_reg <= have;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && have) begin
            pend_reg     <= remain;
            rel_reg      <= src_rel;
            col_reg      <= src_col;
            drive_reg    <= drive_wide[DRIVE_W-1:0];
            ev_valid_reg <= any_ev;
            ev_col_reg   <= any_ev ? col_wide[EV_COL_W-1:0] : '0;
            ev_row_reg   <= any_ev ? row_wide[EV_ROW_W-1:0] : '0;
            ev_rel_reg   <= any_ev && src_rel[idx];
            last_reg     <= (remain == '0);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_column_drive  = drive_reg;
    assign m_event_valid   = ev_valid_reg;
    assign m_event_column  = ev_col_reg;
    assign m_event_row     = ev_row_reg;
    assign m_event_release = ev_rel_reg;
    assign m_last          = last_reg;

endmodule

// ===== rtl/key_matrix_scanner.sv =====
// key_matrix_scanner: top level of the key matrix scanner.
// Instantiates kms_front, kms_queue and kms_back; depends on kms_pkg.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//   s        in         s_valid / s_ready      s_row_levels
//   m        out        m_valid / m_ready      column drive, event, last
//
// A scan tick is taken whenever the two-entry queue has room.
// A tick gives max(1, enabled events) items, one per cycle unless m_ready stalls,
// from the output register; a tick is held in the queue before its first item.
// Reset clears the control and state registers at once; there is no clearing pass.
// m_ready low holds the output; the queue then fills and drops s_ready.
// cfg_ready is always high.
`timescale 1ns / 1ps

module key_matrix_scanner
    import kms_pkg::*;
#(
    parameter int ROW_COUNT    = ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [ROW_LEVELS_W-1:0] s_row_levels,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [DRIVE_W-1:0]      m_column_drive,
    output logic                    m_event_valid,
    output logic [EV_COL_W-1:0]     m_event_column,
    output logic [EV_ROW_W-1:0]     m_event_row,
    output logic                    m_event_release,
    output logic                    m_last
);

    localparam int COL_W   = $clog2(COLUMN_COUNT);
    localparam int ENTRY_W = COL_W + 2 * ROW_COUNT;

    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    logic [ENTRY_W-1:0] q_wdata;
    logic [ENTRY_W-1:0] q_rdata;

    kms_front #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_row_levels (s_row_levels),
        .q_push       (q_push),
        .q_data       (q_wdata),
        .q_full       (q_full)
    );

    kms_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    kms_back #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_data          (q_rdata),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_column_drive  (m_column_drive),
        .m_event_valid   (m_event_valid),
        .m_event_column  (m_event_column),
        .m_event_row     (m_event_row),
        .m_event_release (m_event_release),
        .m_last          (m_last)
    );

endmodule

// ===== test/key_matrix_scanner_tb.sv =====
// key_matrix_scanner_tb: self-checking testbench for the key matrix scanner.
// Scan ticks with random gaps and output stalls; results are checked per field.
// Depends on kms_pkg and key_matrix_scanner.
`timescale 1ns / 1ps

module key_matrix_scanner_tb;
    import kms_pkg::*;

    localparam int ROWS = ROW_COUNT_DEF;
    localparam int COLS = COLUMN_COUNT_DEF;
    localparam int KEYS = ROWS * COLS;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_TICKS = 50;

    // indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct {
        logic [DRIVE_W-1:0]  drive;
        logic                ev_valid;
        logic [EV_COL_W-1:0] column;
        logic [EV_ROW_W-1:0] row;
        logic                is_release;
        logic                last;
    } key_report_t;

    logic                    aclk            = 1'b0;
    logic                    aresetn         = 1'b0;
    logic                    cfg_valid       = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index       = '0;
    logic [CFG_DATA_W-1:0]   cfg_data        = '0;
    logic                    s_valid         = 1'b0;
    logic                    s_ready;
    logic [ROW_LEVELS_W-1:0] s_row_levels    = '1;
    logic                    m_valid;
    logic                    m_ready         = 1'b0;
    logic [DRIVE_W-1:0]      m_column_drive;
    logic                    m_event_valid;
    logic [EV_COL_W-1:0]     m_event_column;
    logic [EV_ROW_W-1:0]     m_event_row;
    logic                    m_event_release;
    logic                    m_last;

    logic [MASK_W-1:0]       press_en_model   = '0;
    logic [MASK_W-1:0]       release_en_model = '0;
    int                      column_model     = 0;
    logic [KEYS-1:0]         keys_down        = '0;

    key_report_t             expected_reports[$];
    logic [ROW_LEVELS_W-1:0] row_queue[$];
    int                      errors    = 0;
    bit                      steady    = 1'b0;
    int                      send_wait = 0;
    int                      recv_wait = 0;

    key_matrix_scanner uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_row_levels   (s_row_levels),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_column_drive (m_column_drive),
        .m_event_valid  (m_event_valid),
        .m_event_column (m_event_column),
        .m_event_row    (m_event_row),
        .m_event_release(m_event_release),
        .m_last         (m_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int draw_wait();
        return steady ? 0 : int'($urandom_range(0, 9));
    endfunction

    // advance the column, diff the rows against the key bitmap, queue the reports
    function automatic void predict_scan(logic [ROW_LEVELS_W-1:0] levels);
        key_report_t batch[$];
        key_report_t r;
        int          key;
        bit          pressed;
        column_model = (column_model + 1) % COLS;
        for (int row = 0; row < ROWS; row++) begin
            key = column_model * ROWS + row;
            pressed = !levels[row];
            if (pressed != keys_down[key]) begin
                keys_down[key] = pressed;
                if (key < MASK_W &&
                    (pressed ? press_en_model[key] : release_en_model[key])) begin
                    r.drive      = DRIVE_W'(1 << column_model);
                    r.ev_valid   = 1'b1;
                    r.column     = EV_COL_W'(column_model);
                    r.row        = EV_ROW_W'(row);
                    r.is_release = !pressed;
                    r.last       = 1'b0;
                    batch.push_back(r);
                end
            end
        end
        if (batch.size() == 0) begin
            r.drive      = DRIVE_W'(1 << column_model);
            r.ev_valid   = 1'b0;
            r.column     = '0;
            r.row        = '0;
            r.is_release = 1'b0;
            r.last       = 1'b0;
            batch.push_back(r);
        end
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) expected_reports.push_back(batch[i]);
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // scan tick driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_wait <= 0;
        end else if (!(s_valid && !s_ready)) begin
            if (s_valid) predict_scan(s_row_levels);
            if (send_wait > 0) begin
                s_valid   <= 1'b0;
                send_wait <= send_wait - 1;
            end else if (row_queue.size() > 0) begin
                s_valid      <= 1'b1;
                s_row_levels <= row_queue.pop_front();
                send_wait    <= draw_wait();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // report monitor
    always @(posedge aclk) begin
        key_report_t want;
        int          stall;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait <= 0;
        end else begin
            stall = recv_wait;
            if (m_valid && m_ready) begin
                stall = draw_wait();
                if (expected_reports.size() == 0) begin
                    errors++;
                    $display("%0t: item with none expected, drive %0h event %0b last %0b",
                             $time, m_column_drive, m_event_valid, m_last);
                end else begin
                    want = expected_reports.pop_front();
                    check_field("column_drive", 8'(want.drive), 8'(m_column_drive));
                    check_field("event_valid", 8'(want.ev_valid), 8'(m_event_valid));
                    check_field("event_column", 8'(want.column), 8'(m_event_column));
                    check_field("event_row", 8'(want.row), 8'(m_event_row));
                    check_field("event_release", 8'(want.is_release), 8'(m_event_release));
                    check_field("last", 8'(want.last), 8'(m_last));
                end
            end
            if (stall > 0) begin
                m_ready   <= 1'b0;
                recv_wait <= stall - 1;
            end else begin
                m_ready   <= 1'b1;
                recv_wait <= 0;
            end
        end
    end

    task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            REG_PRESS_EN:   press_en_model = data;
            REG_RELEASE_EN: release_en_model = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        while (row_queue.size() != 0 || s_valid || expected_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_phase(logic [MASK_W-1:0] press_mask, logic [MASK_W-1:0] release_mask);
        logic [ROW_LEVELS_W-1:0] levels;
        write_register(REG_SPARE_2, CFG_DATA_W'($urandom));
        write_register(REG_PRESS_EN, press_mask);
        write_register(REG_SPARE_3, CFG_DATA_W'($urandom));
        write_register(REG_RELEASE_EN, release_mask);
        for (int i = 0; i < RANDOM_TICKS; i++) begin
            case ($urandom_range(0, 3))
                0:       levels = ROW_LEVELS_W'($urandom);
                1:       levels = '1;
                2:       levels = ~(ROW_LEVELS_W'(1) << $urandom_range(0, ROWS - 1));
                default: levels = '0;
            endcase
            row_queue.push_back(levels);
        end
        wait_idle();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every event enabled: full presses, full releases, partial patterns
        write_register(REG_PRESS_EN, 16'hFFFF);
        write_register(REG_RELEASE_EN, 16'hFFFF);
        row_queue = '{4'h0, 4'hF, 4'h0, 4'h5, 4'hF, 4'hA, 4'hF, 4'hF, 4'hF, 4'hF,
                      4'hE, 4'h7};
        wait_idle();

        // low keys report presses, high keys report releases; spare indexes inert
        write_register(REG_PRESS_EN, 16'h00FF);
        write_register(REG_RELEASE_EN, 16'hFF00);
        write_register(REG_SPARE_2, 16'h0000);
        write_register(REG_SPARE_3, 16'h0000);
        row_queue = '{4'h0, 4'h0, 4'h0, 4'h0, 4'hF, 4'hF, 4'hF, 4'hF};
        wait_idle();

        // nothing reported, bitmap still tracks
        write_register(REG_PRESS_EN, 16'h0000);
        write_register(REG_RELEASE_EN, 16'h0000);
        write_register(REG_SPARE_2, 16'hFFFF);
        write_register(REG_SPARE_3, 16'hFFFF);
        row_queue = '{4'h0, 4'hF};
        wait_idle();

        steady = 1'b1;
        random_phase(16'hFFFF, 16'hFFFF);
        steady = 1'b0;
        random_phase(MASK_W'($urandom), MASK_W'($urandom));
        steady = ($urandom_range(0, 3) == 0);
        random_phase(16'h0000, MASK_W'($urandom));
        steady = 1'b0;
        random_phase(MASK_W'($urandom), 16'hFFFF);

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
